@@ rtl/core/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper: target kinds,
// bank register addresses and the structs passed between decode and top.
// ----------------------------------------------------------------------------
package cbm_pkg;

	typedef enum logic [2:0] {
		KIND_OPEN     = 3'd0,
		KIND_ROM_RD   = 3'd1,
		KIND_SRAM_RD  = 3'd2,
		KIND_SRAM_WR  = 3'd3,
		KIND_REG_LOAD = 3'd4,
		KIND_IGNORED  = 3'd5
	} kind_t;

	localparam int unsigned WinCount = 4;
	localparam int unsigned SubCount = 2;

	// register load addresses
	localparam logic [15:0] ADDR_WIN0 = 16'h4FFF;
	localparam logic [15:0] ADDR_WIN1 = 16'h6FFF;
	localparam logic [15:0] ADDR_WIN2 = 16'h8FFF;
	localparam logic [15:0] ADDR_WIN3 = 16'hAFFF;
	localparam logic [15:0] ADDR_SUB0 = 16'h77FF;
	localparam logic [15:0] ADDR_SUB1 = 16'h7FFF;

	localparam logic [15:0] ADDR_HIGH     = 16'hC000;
	localparam logic [15:0] ADDR_SRAM_END = 16'h4000;
	localparam logic [3:0]  SUB_AREA      = 4'h7;

	typedef struct packed {
		logic [7:0] win0;
		logic [7:0] win1;
		logic [7:0] win2;
		logic [7:0] win3;
		logic [7:0] sub0;
		logic [7:0] sub1;
	} banks_t;

	typedef struct packed {
		kind_t       kind;
		logic [19:0] addr;
		logic [7:0]  data;
	} result_t;

	typedef struct packed {
		logic       win_we;
		logic       sub_we;
		logic [1:0] idx;
		logic [7:0] data;
	} load_t;

endpackage

@@ rtl/core/cartridge_bank_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_unit
// Translates each cartridge bus word (read or write) into its target: open
// bus, a 20-bit rom address, a 14-bit sram address, a bank register load or
// an ignored write. A word passes through the input register, the decode and
// the result register; one word can be accepted every cycle while in_stall is
// low, and the next word is taken while a finished result waits behind a
// stalled output. A bank register load is applied as its word leaves the
// decode, so the word right after it already sees the new mapping.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  target_kind,
	output logic [19:0] mem_address,
	output logic [7:0]  mem_write_data
);

	logic        valid_s1;
	logic        func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic             valid_s2;
	cbm_pkg::result_t result_s2;

	logic [7:0] window_bank_q [cbm_pkg::WinCount];
	logic [7:0] sub_bank_q    [cbm_pkg::SubCount];

	cbm_pkg::banks_t  banks;
	cbm_pkg::result_t result;
	cbm_pkg::load_t   load;

	logic out_free;
	logic advance;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign banks.win0 = window_bank_q[0];
	assign banks.win1 = window_bank_q[1];
	assign banks.win2 = window_bank_q[2];
	assign banks.win3 = window_bank_q[3];
	assign banks.sub0 = sub_bank_q[0];
	assign banks.sub1 = sub_bank_q[1];

	cbm_decode u_decode (
		.func        (func_s1),
		.bus_address (addr_s1),
		.write_data  (data_s1),
		.banks       (banks),
		.result      (result),
		.load        (load)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			addr_s1 <= bus_address;
			data_s1 <= write_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// bank registers, loaded as the word leaves the decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbm_pkg::WinCount; i++) begin
				window_bank_q[i] <= '0;
			end
			for (int i = 0; i < cbm_pkg::SubCount; i++) begin
				sub_bank_q[i] <= '0;
			end
		end else if (advance) begin
			if (load.win_we) begin
				window_bank_q[load.idx] <= load.data;
			end
			if (load.sub_we) begin
				sub_bank_q[load.idx[0]] <= load.data;
			end
		end
	end

	assign out_valid      = valid_s2;
	assign target_kind    = result_s2.kind;
	assign mem_address    = result_s2.addr;
	assign mem_write_data = result_s2.data;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with no word held");

	a_load_applied: assert property (@(posedge clk) disable iff (!arst_n)
		advance && load.win_we && load.idx == 2'd0 |=> window_bank_q[0] == $past(data_s1))
		else $error("window 0 load not applied");

	a_no_addr_unless_mem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target_kind == cbm_pkg::KIND_OPEN || target_kind == cbm_pkg::KIND_REG_LOAD
			|| target_kind == cbm_pkg::KIND_IGNORED) |-> mem_address == '0 && mem_write_data == '0)
		else $error("address or data on a non-memory target");

	a_sram_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target_kind == cbm_pkg::KIND_SRAM_RD || target_kind == cbm_pkg::KIND_SRAM_WR)
		|-> mem_address[19:14] == '0)
		else $error("sram address beyond 16 KB");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && result_s2 == $past(result_s2))
		else $error("stalled result lost or changed");

endmodule

@@ rtl/core/cbm_decode.sv @@
// ----------------------------------------------------------------------------
// cbm_decode
// Address decode of one bus access against the current bank registers:
// gives the target of the access and any bank register load it causes.
// ----------------------------------------------------------------------------
module cbm_decode (
	input  logic                func,
	input  logic [15:0]         bus_address,
	input  logic [7:0]          write_data,
	input  cbm_pkg::banks_t     banks,
	output cbm_pkg::result_t    result,
	output cbm_pkg::load_t      load
);

	logic [2:0] region;
	logic [1:0] win_idx;
	logic [7:0] win_sel;
	logic [7:0] sub_sel;

	assign region  = bus_address[15:13];
	assign win_idx = 2'(region - 3'd2);

	always_comb begin
		case (win_idx)
			2'd0:    win_sel = banks.win0;
			2'd1:    win_sel = banks.win1;
			2'd2:    win_sel = banks.win2;
			default: win_sel = banks.win3;
		endcase
		sub_sel = bus_address[11] ? banks.sub1 : banks.sub0;
	end

	always_comb begin
		result.kind = cbm_pkg::KIND_OPEN;
		result.addr = '0;
		result.data = '0;
		load        = '0;
		load.data   = write_data;
		if (!func) begin
			if (bus_address >= cbm_pkg::ADDR_HIGH) begin
				result.kind = cbm_pkg::KIND_OPEN;
			end else if (bus_address[15:12] == cbm_pkg::SUB_AREA && banks.win1[7]) begin
				// sub-banks sit in the upper half of the rom
				result.kind = cbm_pkg::KIND_ROM_RD;
				result.addr = {1'b1, sub_sel, bus_address[10:0]};
			end else if (region < 3'd2) begin
				if (banks.win0[7]) begin
					result.kind = cbm_pkg::KIND_SRAM_RD;
					result.addr = {6'd0, bus_address[13:0]};
				end
			end else begin
				result.kind = cbm_pkg::KIND_ROM_RD;
				result.addr = {win_sel[6:0], bus_address[12:0]};
			end
		end else if (bus_address < cbm_pkg::ADDR_SRAM_END && banks.win0[7]) begin
			result.kind = cbm_pkg::KIND_SRAM_WR;
			result.addr = {6'd0, bus_address[13:0]};
			result.data = write_data;
		end else begin
			result.kind = cbm_pkg::KIND_REG_LOAD;
			unique case (bus_address)
				cbm_pkg::ADDR_WIN0: begin
					load.win_we = 1'b1;
					load.idx    = 2'd0;
				end
				cbm_pkg::ADDR_WIN1: begin
					load.win_we = 1'b1;
					load.idx    = 2'd1;
				end
				cbm_pkg::ADDR_WIN2: begin
					load.win_we = 1'b1;
					load.idx    = 2'd2;
				end
				cbm_pkg::ADDR_WIN3: begin
					load.win_we = 1'b1;
					load.idx    = 2'd3;
				end
				cbm_pkg::ADDR_SUB0: begin
					load.sub_we = 1'b1;
					load.idx    = 2'd0;
				end
				cbm_pkg::ADDR_SUB1: begin
					load.sub_we = 1'b1;
					load.idx    = 2'd1;
				end
				default: begin
					result.kind = cbm_pkg::KIND_IGNORED;
				end
			endcase
		end
	end

endmodule
